// ----- rtl/core/tbdu_pkg.sv -----
// ----------------------------------------------------------------------------
// tbdu_pkg
// Shared types and constants for the terminal byte to code point decoder.
// ----------------------------------------------------------------------------
package tbdu_pkg;

   localparam int unsigned CODE_W      = 16;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned TBL_IDX_W   = 7;
   localparam int unsigned TBL_DEPTH   = 1 << TBL_IDX_W;
   localparam int unsigned CSR_IDX_W   = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_CODEPAGE_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INVALID_CODE  = 1'd1;

   localparam logic CMD_DECODE      = 1'b0;
   localparam logic CMD_TABLE_WRITE = 1'b1;

   localparam logic [CODE_W-1:0] INVALID_CODE_RESET = 16'hFFFD;

   typedef struct packed {
      logic              emit;
      logic              malformed;
      logic [CODE_W-1:0] code;
   } utf8_res_type;

endpackage

// ----- rtl/core/tbdu_ram.sv -----
// ----------------------------------------------------------------------------
// tbdu_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tbdu_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/tbdu_utf8.sv -----
// ----------------------------------------------------------------------------
// tbdu_utf8
// UTF-8 sequence assembler: phase state, partial code and result decode.
// ----------------------------------------------------------------------------
module tbdu_utf8
   import tbdu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic               clear,
   input  logic [BYTE_W-1:0]  byte_in,
   input  logic [CODE_W-1:0]  invalid_code,
   output utf8_res_type       res
);

   typedef enum logic [1:0] {
      PH_IDLE       = 2'd0,
      PH_TWO_LAST   = 2'd1,
      PH_THREE_MID  = 2'd2,
      PH_THREE_LAST = 2'd3
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [CODE_W-1:0] partial_ff, partial_in;
   logic              cont;
   logic              err;

   always_comb begin
      cont       = (byte_in[7:6] == 2'b10);
      err        = 1'b0;
      phase_in   = phase_ff;
      partial_in = partial_ff;
      res        = '{emit: 1'b0, malformed: 1'b0, code: '0};
      case (phase_ff)
         PH_IDLE: begin
            if (!byte_in[7]) begin
               res.emit = 1'b1;
               res.code = {8'd0, byte_in};
            end else if (byte_in[7:5] == 3'b110) begin
               partial_in = {5'd0, byte_in[4:0], 6'd0};
               phase_in   = PH_TWO_LAST;
            end else if (byte_in[7:4] == 4'b1110) begin
               partial_in = {byte_in[3:0], 12'd0};
               phase_in   = PH_THREE_MID;
            end else begin
               err = 1'b1;
            end
         end
         PH_TWO_LAST, PH_THREE_LAST: begin
            if (cont) begin
               res.emit   = 1'b1;
               res.code   = partial_ff | {10'd0, byte_in[5:0]};
               phase_in   = PH_IDLE;
               partial_in = '0;
            end else begin
               err = 1'b1;
            end
         end
         PH_THREE_MID: begin
            if (cont) begin
               partial_in = partial_ff | {4'd0, byte_in[5:0], 6'd0};
               phase_in   = PH_THREE_LAST;
            end else begin
               err = 1'b1;
            end
         end
         default: begin
            err = 1'b1;
         end
      endcase
      if (err) begin
         res.emit      = 1'b1;
         res.malformed = 1'b1;
         res.code      = invalid_code;
         phase_in      = PH_IDLE;
         partial_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         phase_ff   <= PH_IDLE;
         partial_ff <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         partial_ff <= partial_in;
      end
   end

endmodule

// ----- rtl/core/terminal_byte_to_unicode_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// terminal_byte_to_unicode_decoder_unit
// Decodes a terminal byte stream into 16-bit code points.
//
// Words enter on the req_ channel: a decode word carries one byte, a table
// word loads one entry of the 128-entry codepage table. Decoded code points
// leave on the rsp_ channel with a malformed flag; lead bytes and table
// writes give no output word. Registers are written on the csr_ channel,
// which is always ready; the user must write them only while the unit is
// idle, which the unit does not enforce. Index 0 selects codepage mode (and
// returns the UTF-8 assembler to idle), index 1 sets the code sent for
// malformed UTF-8. Throughput is one word per cycle while rsp_ is not
// stalled. A result passes the read stage (table RAM read), then the output
// register. A word is still accepted while a result waits in the output
// register; req_stall rises only once the read stage is also full. Reset
// restores the UTF-8 state and the registers and clears the table valid bits
// at once, so unwritten entries read as zero with no clearing pass.
// ----------------------------------------------------------------------------
module terminal_byte_to_unicode_decoder_unit
   import tbdu_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_cmd,
   input  logic [BYTE_W-1:0]    req_byte_in,
   input  logic [TBL_IDX_W-1:0] req_table_index,
   input  logic [CODE_W-1:0]    req_table_value,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CODE_W-1:0]    rsp_code_point,
   output logic                 rsp_malformed,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CODE_W-1:0]    csr_wdata
);

   logic              codepage_mode_ff;
   logic [CODE_W-1:0] invalid_code_ff;
   logic              csr_wr;

   logic [TBL_DEPTH-1:0] tbl_valid_ff;

   logic              accept;
   logic              acc_write;
   logic              acc_decode;
   logic              cp_upper;
   logic              utf8_step;
   utf8_res_type      utf8_res;
   logic [CODE_W-1:0] ram_rd_data;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_use_ram_ff;
   logic              s1_entry_ok_ff;
   logic [CODE_W-1:0] s1_code_ff;
   logic              s1_malformed_ff;
   logic [CODE_W-1:0] s1_result;
   logic              s1_move;
   logic              out_free;

   logic              rsp_valid_ff;
   logic [CODE_W-1:0] rsp_code_ff;
   logic              rsp_malformed_ff;

   // configuration
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         codepage_mode_ff <= 1'b0;
         invalid_code_ff  <= INVALID_CODE_RESET;
      end else if (csr_wr) begin
         if (csr_index == CSR_CODEPAGE_MODE) begin
            codepage_mode_ff <= csr_wdata[0];
         end
         if (csr_index == CSR_INVALID_CODE) begin
            invalid_code_ff <= csr_wdata;
         end
      end
   end

   // input handshake
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign accept     = req_valid && !req_stall;
   assign acc_write  = accept && (req_cmd == CMD_TABLE_WRITE);
   assign acc_decode = accept && (req_cmd == CMD_DECODE);
   assign cp_upper   = codepage_mode_ff && req_byte_in[7];
   assign utf8_step  = acc_decode && !codepage_mode_ff;

   tbdu_utf8 u_utf8 (
      .clock        (clock),
      .reset        (reset),
      .step         (utf8_step),
      .clear        (csr_wr && (csr_index == CSR_CODEPAGE_MODE)),
      .byte_in      (req_byte_in),
      .invalid_code (invalid_code_ff),
      .res          (utf8_res)
   );

   tbdu_ram #(
      .WIDTH (CODE_W),
      .DEPTH (TBL_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (acc_write),
      .wr_addr (req_table_index),
      .wr_data (req_table_value),
      .rd_en   (acc_decode && cp_upper),
      .rd_addr (req_byte_in[TBL_IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tbl_valid_ff <= '0;
      end else if (acc_write) begin
         tbl_valid_ff[req_table_index] <= 1'b1;
      end
   end

   // read stage
   always_comb begin
      s1_valid_in = s1_valid_ff && !s1_move;
      if (acc_decode) begin
         s1_valid_in = codepage_mode_ff || utf8_res.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (acc_decode) begin
         s1_use_ram_ff   <= cp_upper;
         s1_entry_ok_ff  <= tbl_valid_ff[req_byte_in[TBL_IDX_W-1:0]];
         s1_code_ff      <= codepage_mode_ff ? {8'd0, req_byte_in} : utf8_res.code;
         s1_malformed_ff <= !codepage_mode_ff && utf8_res.malformed;
      end
   end

   assign s1_result = s1_use_ram_ff ? (s1_entry_ok_ff ? ram_rd_data : '0) : s1_code_ff;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (s1_move) begin
         rsp_code_ff      <= s1_result;
         rsp_malformed_ff <= s1_malformed_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_code_point = rsp_code_ff;
   assign rsp_malformed  = rsp_malformed_ff;

endmodule
